[hw/rtl/pt_pkg.sv]
// Shared constants and helpers for the pressure/temperature compensation core.
// Depends on nothing; pt_temp, pt_div, the core and the testbench import it.
package pt_pkg;

  // Configuration register indexes.
  localparam logic [7:0] CFG_TEMP_CALIB    = 8'd0;
  localparam logic [7:0] CFG_PRESS_CALIB_A = 8'd1;
  localparam logic [7:0] CFG_PRESS_CALIB_B = 8'd2;
  localparam logic [7:0] CFG_PRESS_CALIB_C = 8'd3;

  // Compensation constants.
  localparam logic [63:0] FINE_OFFSET = 64'd128000;
  localparam logic [63:0] PRESS_BASE  = 64'd1048576;
  localparam logic [63:0] PRESS_SCALE = 64'd3125;
  localparam logic [31:0] TEMP_ROUND  = 32'd128;
  localparam int          ONE_SHIFT   = 47;
  localparam int          DIV_SHIFT   = 33;

  // Pipeline geometry.
  localparam int DIV_STEPS = 64;
  localparam int LAT       = 82;

  // Sign-extend a 16-bit calibration word to 64 bits.
  function automatic logic [63:0] sext16(input logic [15:0] v);
    sext16 = {{48{v[15]}}, v};
  endfunction

endpackage

[hw/rtl/pt_if.sv]
// Channel interfaces of the compensation core: input, result and configuration.
// Depends on nothing.
interface pt_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_temperature;
  logic [19:0] raw_pressure_in;
  modport source (output valid, output raw_temperature, output raw_pressure_in, input ready);
  modport sink (input valid, input raw_temperature, input raw_pressure_in, output ready);
endinterface

interface pt_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] temperature_centi;
  logic signed [31:0] fine_temperature;
  logic        [31:0] pressure_q24_8;
  logic               divide_fault;
  modport source (output valid, output temperature_centi, output fine_temperature,
                  output pressure_q24_8, output divide_fault, input ready);
  modport sink (input valid, input temperature_centi, input fine_temperature,
                input pressure_q24_8, input divide_fault, output ready);
endinterface

interface pt_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [63:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[hw/rtl/pt_mul64.sv]
// Two-stage 64x64 multiplier keeping the low 64 bits, built from 32x32 products.
// Depends on nothing; the caller supplies the pipeline enable.
module pt_mul64 (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p
);

  logic [63:0] ll_full;
  logic [63:0] lh_full;
  logic [63:0] hl_full;
  logic [63:0] ll_r;
  logic [31:0] lh_r;
  logic [31:0] hl_r;
  logic [63:0] p_r;

  // Partial products; the high-by-high term falls outside the kept bits.
  assign ll_full = a[31:0] * b[31:0];
  assign lh_full = a[31:0] * b[63:32];
  assign hl_full = a[63:32] * b[31:0];

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= ll_full;
      lh_r <= lh_full[31:0];
      hl_r <= hl_full[31:0];
      p_r  <= ll_r + {lh_r + hl_r, 32'd0};
    end
  end

  assign p = p_r;

endmodule

[hw/rtl/pt_temp.sv]
// Temperature compensation pipeline: fine temperature after four stages,
// hundredths of a degree after five. Depends on pt_pkg.
module pt_temp import pt_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [19:0]        raw_temperature,
  input  logic [15:0]        t1,
  input  logic signed [15:0] t2,
  input  logic signed [15:0] t3,
  output logic signed [31:0] fine_s4,
  output logic signed [31:0] fine_s5,
  output logic signed [31:0] centi_s5
);

  logic signed [17:0] a_nxt, a_r;
  logic signed [16:0] b_nxt, b_r;
  logic signed [33:0] pa_r, bb_r;
  logic signed [31:0] v1_r;
  logic signed [31:0] bbs;
  logic signed [47:0] pc_r;
  logic signed [31:0] v2;
  logic signed [31:0] fine_r, fine5_r, centi_r;
  logic        [31:0] f5;

  // Offsets of the raw reading against T1.
  assign a_nxt = $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
  assign b_nxt = $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, t1});

  // Products wrap to 32 bits before each arithmetic shift.
  assign bbs = $signed(bb_r[31:0]) >>> 12;
  assign v2  = $signed(pc_r[31:0]) >>> 14;
  assign f5  = (fine_r << 2) + fine_r + TEMP_ROUND;

  always_ff @(posedge clk) begin
    if (en) begin
      a_r     <= a_nxt;
      b_r     <= b_nxt;
      pa_r    <= a_r * t2;
      bb_r    <= b_r * b_r;
      v1_r    <= $signed(pa_r[31:0]) >>> 11;
      pc_r    <= bbs * t3;
      fine_r  <= v1_r + v2;
      fine5_r <= fine_r;
      centi_r <= $signed(f5) >>> 8;
    end
  end

  assign fine_s4  = fine_r;
  assign fine_s5  = fine5_r;
  assign centi_s5 = centi_r;

endmodule

[hw/rtl/pt_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with sign fix-up.
// Depends on pt_pkg for the step count.
module pt_div import pt_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] ma,
  input  logic [63:0] mb,
  input  logic        neg,
  output logic [63:0] q
);

  logic [63:0] rem_r [1:DIV_STEPS];
  logic [63:0] aq_r  [1:DIV_STEPS];
  logic [63:0] mb_r  [1:DIV_STEPS];
  logic        neg_r [1:DIV_STEPS];
  logic [63:0] rem_nxt [1:DIV_STEPS];
  logic [63:0] aq_nxt  [1:DIV_STEPS];
  logic [63:0] rin [1:DIV_STEPS];
  logic [63:0] ain [1:DIV_STEPS];
  logic [63:0] bin [1:DIV_STEPS];
  logic [64:0] trial [1:DIV_STEPS];
  logic [63:0] q_r;

  // Each stage shifts in one dividend bit and tries a subtraction.
  always_comb begin
    for (int j = 1; j <= DIV_STEPS; j++) begin
      if (j == 1) begin
        rin[j] = 64'd0;
        ain[j] = ma;
        bin[j] = mb;
      end else begin
        rin[j] = rem_r[j-1];
        ain[j] = aq_r[j-1];
        bin[j] = mb_r[j-1];
      end
      trial[j]   = {rin[j], ain[j][63]} - {1'b0, bin[j]};
      rem_nxt[j] = trial[j][64] ? {rin[j][62:0], ain[j][63]} : trial[j][63:0];
      aq_nxt[j]  = {ain[j][62:0], ~trial[j][64]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 1; j <= DIV_STEPS; j++) begin
        rem_r[j] <= rem_nxt[j];
        aq_r[j]  <= aq_nxt[j];
        mb_r[j]  <= bin[j];
        neg_r[j] <= (j == 1) ? neg : neg_r[(j > 1) ? j - 1 : 1];
      end
      q_r <= neg_r[DIV_STEPS] ? (64'd0 - aq_r[DIV_STEPS]) : aq_r[DIV_STEPS];
    end
  end

  assign q = q_r;

endmodule

[hw/rtl/pressure_temp_compensation_core.sv]
// Pressure and temperature compensation core, fully pipelined.
// Each transfer on in_ch carries a raw 20-bit temperature and pressure reading;
// each transfer on out_ch returns temperature in 0.01 degC, the fine
// temperature, pressure as unsigned Q24.8 pascals and a divide fault flag.
// The user is to write calibration words through cfg_ch (always ready) only
// while idle; the block does not enforce this. The result passes through 82
// register stages, the first loaded at the input transfer. Throughput is one
// item per cycle unless out_ch stalls; the 64-stage divider sets most of the
// latency, and every 64-bit multiplier is split into 32x32 partial products.
// The whole pipeline advances together: when the result register holds an
// item the receiver has not taken, the pipeline and in_ch.ready hold, and
// nothing is lost or repeated. A zero divisor gives pressure 0 with the fault
// flag set. Reset clears the valid bits and all calibration registers.
// Depends on pt_pkg, pt_if, pt_temp, pt_mul64 and pt_div.
module pressure_temp_compensation_core import pt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  pt_in_if.sink     in_ch,
  pt_out_if.source  out_ch,
  pt_cfg_if.sink    cfg_ch
);

  logic        en;
  logic [LAT:1] vld_r;
  logic [47:0] temp_calib_r;
  logic [63:0] press_calib_a_r, press_calib_b_r;
  logic [15:0] press_calib_c_r;
  logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;

  logic signed [31:0] fine_s4, fine_s5, centi_s5;
  logic [19:0] rp_r [1:9];
  logic [63:0] d;
  logic [63:0] dd, dp5, dp2, ddp6, ddp3;
  logic [63:0] ddp3_sh;
  logic [63:0] dp5_r [7:8];
  logic [63:0] dp2_r [7:8];
  logic [63:0] w2_r, w1a_r;
  logic [63:0] pb, n0, w1p, np, w1;
  logic [63:0] ma_r, mb_r;
  logic        neg_r;
  logic        fault_r [12:81];
  logic [31:0] centi_r [6:81];
  logic [31:0] fine_r  [6:81];
  logic [63:0] q, ps, p9ps, p8p, c1p;
  logic [63:0] c1_sh;
  logic [63:0] ps_r [78:79];
  logic [63:0] q_r  [78:81];
  logic [63:0] c2_r [80:81];
  logic [63:0] sum, sum_sh, res;
  logic [31:0] centi_o_r, fine_o_r, press_o_r;
  logic        fault_o_r;

  // Pipeline advance and valid bits.
  assign en          = !vld_r[LAT] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-1:1], in_ch.valid};
    end
  end

  // Configuration registers; writes to unknown indexes are dropped.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_calib_r    <= '0;
      press_calib_a_r <= '0;
      press_calib_b_r <= '0;
      press_calib_c_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_TEMP_CALIB:    temp_calib_r    <= cfg_ch.data[47:0];
        CFG_PRESS_CALIB_A: press_calib_a_r <= cfg_ch.data;
        CFG_PRESS_CALIB_B: press_calib_b_r <= cfg_ch.data;
        CFG_PRESS_CALIB_C: press_calib_c_r <= cfg_ch.data[15:0];
        default: ;
      endcase
    end
  end

  // Calibration coefficients as 64-bit two's complement words.
  assign p1 = {48'd0, press_calib_a_r[15:0]};
  assign p2 = sext16(press_calib_a_r[31:16]);
  assign p3 = sext16(press_calib_a_r[47:32]);
  assign p4 = sext16(press_calib_a_r[63:48]);
  assign p5 = sext16(press_calib_b_r[15:0]);
  assign p6 = sext16(press_calib_b_r[31:16]);
  assign p7 = sext16(press_calib_b_r[47:32]);
  assign p8 = sext16(press_calib_b_r[63:48]);
  assign p9 = sext16(press_calib_c_r);

  // Temperature path.
  pt_temp u_temp (
    .clk             (clk),
    .en              (en),
    .raw_temperature (in_ch.raw_temperature),
    .t1              (temp_calib_r[15:0]),
    .t2              ($signed(temp_calib_r[31:16])),
    .t3              ($signed(temp_calib_r[47:32])),
    .fine_s4         (fine_s4),
    .fine_s5         (fine_s5),
    .centi_s5        (centi_s5)
  );

  // Side data that travels alongside the arithmetic.
  always_ff @(posedge clk) begin
    if (en) begin
      rp_r[1] <= in_ch.raw_pressure_in;
      for (int i = 2; i <= 9; i++) rp_r[i] <= rp_r[i-1];
      centi_r[6] <= centi_s5;
      fine_r[6]  <= fine_s5;
      for (int i = 7; i <= 81; i++) begin
        centi_r[i] <= centi_r[i-1];
        fine_r[i]  <= fine_r[i-1];
      end
      for (int i = 13; i <= 81; i++) fault_r[i] <= fault_r[i-1];
      dp5_r[7] <= dp5;
      dp5_r[8] <= dp5_r[7];
      dp2_r[7] <= dp2;
      dp2_r[8] <= dp2_r[7];
    end
  end

  // First products of the offset fine temperature.
  assign d = {{32{fine_s4[31]}}, fine_s4} - FINE_OFFSET;

  pt_mul64 u_dd  (.clk(clk), .en(en), .a(d), .b(d),  .p(dd));
  pt_mul64 u_dp5 (.clk(clk), .en(en), .a(d), .b(p5), .p(dp5));
  pt_mul64 u_dp2 (.clk(clk), .en(en), .a(d), .b(p2), .p(dp2));
  pt_mul64 u_dd6 (.clk(clk), .en(en), .a(dd), .b(p6), .p(ddp6));
  pt_mul64 u_dd3 (.clk(clk), .en(en), .a(dd), .b(p3), .p(ddp3));

  // Arithmetic shifts are kept apart so the unsigned sums do not turn them logical.
  assign ddp3_sh = $signed(ddp3) >>> 8;

  // Partial sums of the two pressure terms.
  always_ff @(posedge clk) begin
    if (en) begin
      w2_r  <= ddp6 + (dp5_r[8] << 17) + (p4 << 35);
      w1a_r <= ddp3_sh + (dp2_r[8] << 12) + (64'd1 << ONE_SHIFT);
    end
  end

  assign pb = PRESS_BASE - {44'd0, rp_r[9]};
  assign n0 = (pb << 31) - w2_r;

  pt_mul64 u_w1 (.clk(clk), .en(en), .a(w1a_r), .b(p1),          .p(w1p));
  pt_mul64 u_np (.clk(clk), .en(en), .a(n0),    .b(PRESS_SCALE), .p(np));

  // Divisor, signs and magnitudes for the divider.
  assign w1 = $signed(w1p) >>> DIV_SHIFT;

  always_ff @(posedge clk) begin
    if (en) begin
      ma_r        <= np[63] ? (64'd0 - np) : np;
      mb_r        <= w1[63] ? (64'd0 - w1) : w1;
      neg_r       <= np[63] ^ w1[63];
      fault_r[12] <= (w1 == 64'd0);
    end
  end

  pt_div u_div (
    .clk (clk),
    .en  (en),
    .ma  (ma_r),
    .mb  (mb_r),
    .neg (neg_r),
    .q   (q)
  );

  // Correction terms on the quotient.
  assign ps = $signed(q) >>> 13;

  pt_mul64 u_p9 (.clk(clk), .en(en), .a(ps),   .b(p9),       .p(p9ps));
  pt_mul64 u_p8 (.clk(clk), .en(en), .a(q),    .b(p8),       .p(p8p));
  pt_mul64 u_c1 (.clk(clk), .en(en), .a(p9ps), .b(ps_r[79]), .p(c1p));

  always_ff @(posedge clk) begin
    if (en) begin
      ps_r[78] <= ps;
      ps_r[79] <= ps_r[78];
      q_r[78]  <= q;
      for (int i = 79; i <= 81; i++) q_r[i] <= q_r[i-1];
      c2_r[80] <= $signed(p8p) >>> 19;
      c2_r[81] <= c2_r[80];
    end
  end

  // Final pressure and result register.
  assign c1_sh  = $signed(c1p) >>> 25;
  assign sum    = q_r[81] + c1_sh + c2_r[81];
  assign sum_sh = $signed(sum) >>> 8;
  assign res    = sum_sh + (p7 << 4);

  always_ff @(posedge clk) begin
    if (en) begin
      centi_o_r <= centi_r[81];
      fine_o_r  <= fine_r[81];
      press_o_r <= fault_r[81] ? 32'd0 : res[31:0];
      fault_o_r <= fault_r[81];
    end
  end

  assign out_ch.valid             = vld_r[LAT];
  assign out_ch.temperature_centi = $signed(centi_o_r);
  assign out_ch.fine_temperature  = $signed(fine_o_r);
  assign out_ch.pressure_q24_8    = press_o_r;
  assign out_ch.divide_fault      = fault_o_r;

endmodule

[tb/tb.sv]
// Testbench for pressure_temp_compensation_core: directed and random readings
// checked against an in-bench integer compensation predictor.
// Depends on pt_pkg, pt_if and the core RTL.
`timescale 1ns / 1ps

module tb;
  import pt_pkg::*;

  typedef struct packed {
    logic signed [31:0] centi;
    logic signed [31:0] fine;
    logic [31:0]        press;
    logic               fault;
  } comp_result_t;

  logic clk;
  logic rst_n;
  pt_in_if  in_ch ();
  pt_out_if out_ch ();
  pt_cfg_if cfg_ch ();

  pressure_temp_compensation_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  // Calibration shadow and expected results.
  logic [47:0] cal_temp;
  logic [63:0] cal_pa, cal_pb;
  logic [15:0] cal_pc;
  comp_result_t pending_results[$];
  int n_errors, n_checked, n_faults, cycle_count;
  int send_idle_pct, recv_stall_pct;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Generous watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  function automatic logic [63:0] s16(input logic [63:0] r, input int pos);
    logic [15:0] v;
    v = r[pos +: 16];
    return {{48{v[15]}}, v};
  endfunction

  // Integer compensation of one reading with the current calibration.
  function automatic comp_result_t compensate(input logic [19:0] rt, input logic [19:0] rp);
    comp_result_t r;
    logic signed [31:0] t1, t2, t3, a, b, v1, v2, fine;
    logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, d, w1, w2, p, ps, c1, c2;
    logic [63:0] ua, ub, q;
    t1 = {16'd0, cal_temp[15:0]};
    t2 = 32'(s16({16'd0, cal_temp}, 16));
    t3 = 32'(s16({16'd0, cal_temp}, 32));
    a = $signed({15'd0, rt[19:3]}) - (t1 <<< 1);
    v1 = (a * t2) >>> 11;
    b = $signed({16'd0, rt[19:4]}) - t1;
    v2 = (((b * b) >>> 12) * t3) >>> 14;
    fine = v1 + v2;
    r.fine = fine;
    r.centi = (fine * 5 + 128) >>> 8;
    p1 = {48'd0, cal_pa[15:0]};
    p2 = s16(cal_pa, 16); p3 = s16(cal_pa, 32); p4 = s16(cal_pa, 48);
    p5 = s16(cal_pb, 0);  p6 = s16(cal_pb, 16); p7 = s16(cal_pb, 32);
    p8 = s16(cal_pb, 48); p9 = s16({48'd0, cal_pc}, 0);
    d = 64'(fine) - 64'sd128000;
    w2 = d * d * p6;
    w2 = w2 + ((d * p5) <<< 17);
    w2 = w2 + (p4 <<< 35);
    w1 = ((d * d * p3) >>> 8) + ((d * p2) <<< 12);
    w1 = (((64'sd1 <<< 47) + w1) * p1) >>> 33;
    r.press = '0;
    r.fault = (w1 == 0);
    if (w1 != 0) begin
      p = 64'sd1048576 - $signed({44'd0, rp});
      p = ((p <<< 31) - w2) * 64'sd3125;
      // Signed division truncating toward zero, done on magnitudes.
      ua = p[63] ? -p : p;
      ub = w1[63] ? -w1 : w1;
      q = ua / ub;
      p = (p[63] != w1[63]) ? -q : q;
      ps = p >>> 13;
      c1 = (p9 * ps * ps) >>> 25;
      c2 = (p8 * p) >>> 19;
      p = ((p + c1 + c2) >>> 8) + (p7 <<< 4);
      r.press = p[31:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got, input logic [31:0] exp);
    n_errors++;
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, exp, cycle_count);
  endtask

  // Result checker and receiver stall.
  always @(posedge clk) begin
    comp_result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_ch.pressure_q24_8, 32'd0);
      end else begin
        e = pending_results.pop_front();
        n_checked++;
        if (e.fault) n_faults++;
        if (out_ch.temperature_centi !== e.centi)
          report_mismatch("temperature_centi", out_ch.temperature_centi, e.centi);
        if (out_ch.fine_temperature !== e.fine)
          report_mismatch("fine_temperature", out_ch.fine_temperature, e.fine);
        if (out_ch.pressure_q24_8 !== e.press)
          report_mismatch("pressure_q24_8", out_ch.pressure_q24_8, e.press);
        if (out_ch.divide_fault !== e.fault)
          report_mismatch("divide_fault", {31'd0, out_ch.divide_fault}, {31'd0, e.fault});
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // One register write, after which the channel is left quiet again.
  task automatic write_cfg(input logic [7:0] idx, input logic [63:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_TEMP_CALIB:    cal_temp = val[47:0];
      CFG_PRESS_CALIB_A: cal_pa = val;
      CFG_PRESS_CALIB_B: cal_pb = val;
      CFG_PRESS_CALIB_C: cal_pc = val[15:0];
      default: ;
    endcase
  endtask

  // Sends one reading, with optional idle cycles ahead of it. Valid stays
  // high after the transfer so the next reading can follow at once.
  task automatic send_reading(input logic [19:0] rt, input logic [19:0] rp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.raw_temperature <= rt;
    in_ch.raw_pressure_in <= rp;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(compensate(rt, rp));
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
  endtask

  // Typical datasheet-like calibration.
  task automatic load_typical_cal();
    write_cfg(CFG_TEMP_CALIB, {16'd0, 16'hFC18, 16'd26435, 16'd27504});
    write_cfg(CFG_PRESS_CALIB_A, {16'd2855, 16'd8192, 16'hD5D0, 16'd36477});
    write_cfg(CFG_PRESS_CALIB_B, {16'hC0B3, 16'd15500, 16'hFFF9, 16'd140});
    write_cfg(CFG_PRESS_CALIB_C, 64'd6000);
  endtask

  task automatic test_reset_cal();
    send_reading(20'd0, 20'd0);
    send_reading(20'hFFFFF, 20'hFFFFF);
    drain();
  endtask

  task automatic test_directed();
    load_typical_cal();
    send_reading(20'd519888, 20'd415148);
    send_reading(20'd0, 20'd0);
    send_reading(20'hFFFFF, 20'hFFFFF);
    send_reading(20'hFFFFF, 20'd0);
    send_reading(20'd0, 20'hFFFFF);
    send_reading(20'h80000, 20'h80000);
    send_reading(20'h55555, 20'hAAAAA);
    drain();
    // Extreme calibration words, including the most negative slices.
    write_cfg(CFG_TEMP_CALIB, 64'hFFFF_8000_7FFF_FFFF);
    write_cfg(CFG_PRESS_CALIB_A, 64'h8000_7FFF_8000_FFFF);
    write_cfg(CFG_PRESS_CALIB_B, 64'h7FFF_8000_7FFF_8000);
    write_cfg(CFG_PRESS_CALIB_C, 64'h8000);
    write_cfg(8'd7, 64'hDEAD);
    send_reading(20'd0, 20'd0);
    send_reading(20'hFFFFF, 20'hFFFFF);
    send_reading(20'h12345, 20'hFEDCB);
    drain();
    // Zero divisor: P1 of zero forces the fault path.
    write_cfg(CFG_PRESS_CALIB_A, 64'h1234_5678_9ABC_0000);
    send_reading(20'd519888, 20'd415148);
    send_reading(20'hFFFFF, 20'd1);
    drain();
  endtask

  task automatic test_random(input int count);
    for (int k = 0; k < count; k++) begin
      if (k % 25 == 0) begin
        drain();
        if ($urandom_range(3) == 0) begin
          write_cfg(CFG_TEMP_CALIB, {$urandom, $urandom});
          write_cfg(CFG_PRESS_CALIB_A, {$urandom, $urandom});
          write_cfg(CFG_PRESS_CALIB_B, {$urandom, $urandom});
          write_cfg(CFG_PRESS_CALIB_C, 64'($urandom));
        end else if ($urandom_range(5) == 0) begin
          write_cfg(CFG_PRESS_CALIB_A, {16'd0, $urandom, 16'd0});
        end else begin
          load_typical_cal();
        end
      end
      if ($urandom_range(3) == 0)
        send_reading(20'($urandom), 20'($urandom));
      else
        send_reading(20'($urandom_range(550000, 450000)),
                     20'($urandom_range(500000, 250000)));
    end
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.raw_temperature = '0;
    in_ch.raw_pressure_in = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    cal_temp = '0; cal_pa = '0; cal_pb = '0; cal_pc = '0;
    n_errors = 0; n_checked = 0; n_faults = 0; cycle_count = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_cal();
    test_directed();
    // Idling phases: none, sender, receiver, both.
    test_random(110);
    send_idle_pct = 59;
    test_random(110);
    send_idle_pct = 0; recv_stall_pct = 59;
    test_random(110);
    send_idle_pct = 21; recv_stall_pct = 21;
    test_random(110);
    $display("Checked %0d results (%0d with divide fault) over directed, extreme and random",
             n_checked, n_faults);
    $display("calibration sets, with sender and receiver idling phases.");
    if (n_errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
